@@ hdl/mlptw_pkg.sv @@
package mlptw_pkg;

    localparam int PAGE_OFFSET_BITS_DEF = 12;
    localparam int LEVELS_DEF           = 4;
    localparam int PHYS_PAGES_DEF       = 64;

    localparam int VADDR_W = 64;
    localparam int PADDR_W = 64;
    localparam int PTE_MARK_BITS = 3;

    localparam logic [PADDR_W-1:0] PADDR_FAULT = {PADDR_W{1'b1}};

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_XLATE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_NO_PAGES = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        WS_CLEAR,
        WS_IDLE,
        WS_ISSUE,
        WS_WALK,
        WS_RESULT
    } walk_state_t;

endpackage

@@ hdl/mlptw_store.sv @@
module mlptw_store #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 7,
    parameter int DEPTH  = 32768
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mlptw_walker.sv @@
module mlptw_walker #(
    parameter int PAGE_OFFSET_BITS = mlptw_pkg::PAGE_OFFSET_BITS_DEF,
    parameter int LEVELS           = mlptw_pkg::LEVELS_DEF,
    parameter int PHYS_PAGES       = mlptw_pkg::PHYS_PAGES_DEF,
    localparam int IDX_W  = PAGE_OFFSET_BITS - mlptw_pkg::PTE_MARK_BITS,
    localparam int PAGE_W = $clog2(PHYS_PAGES),
    localparam int ADDR_W = PAGE_W + IDX_W,
    localparam int DATA_W = PAGE_W + 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_mode,
    input  logic [mlptw_pkg::VADDR_W-1:0]   in_vaddr,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [mlptw_pkg::PADDR_W-1:0]   res_paddr,
    output mlptw_pkg::status_t              res_status,
    output logic                            mem_we,
    output logic [ADDR_W-1:0]               mem_waddr,
    output logic [DATA_W-1:0]               mem_wdata,
    output logic [ADDR_W-1:0]               mem_raddr,
    input  logic [DATA_W-1:0]               mem_rdata
);

    localparam int DEPTH  = PHYS_PAGES * (1 << IDX_W);
    localparam int CNT_W  = $clog2(PHYS_PAGES + 1);
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int WALK_W = LEVELS * IDX_W;
    localparam int EXT_W  = mlptw_pkg::VADDR_W + WALK_W;

    mlptw_pkg::walk_state_t state_reg, state_next;
    logic [ADDR_W-1:0]           clr_reg, clr_next;
    logic [PAGE_W-1:0]           root_reg, root_next;
    logic [CNT_W-1:0]            free_reg, free_next;
    logic                        mode_reg, mode_next;
    logic [WALK_W-1:0]           walk_reg, walk_next;
    logic [PAGE_OFFSET_BITS-1:0] off_reg, off_next;
    logic [PAGE_W-1:0]           cur_reg, cur_next;
    logic [LVL_W-1:0]            lvl_reg, lvl_next;
    logic [mlptw_pkg::PADDR_W-1:0] paddr_reg, paddr_next;
    mlptw_pkg::status_t          status_reg, status_next;

    logic [EXT_W-1:0]  vext;
    logic [IDX_W-1:0]  idx_cur;
    logic [WALK_W-1:0] walk_shift;
    logic [PAGE_W-1:0] page_sel;
    logic              pages_left;

    assign vext       = {{WALK_W{1'b0}}, in_vaddr};
    assign idx_cur    = walk_reg[WALK_W-1 -: IDX_W];
    assign walk_shift = walk_reg << IDX_W;
    assign pages_left = (free_reg < CNT_W'(PHYS_PAGES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlptw_pkg::WS_CLEAR;
            clr_reg   <= '0;
            root_reg  <= '0;
            free_reg  <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            root_reg  <= root_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        walk_reg   <= walk_next;
        off_reg    <= off_next;
        cur_reg    <= cur_next;
        lvl_reg    <= lvl_next;
        paddr_reg  <= paddr_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        root_next   = root_reg;
        free_next   = free_reg;
        mode_next   = mode_reg;
        walk_next   = walk_reg;
        off_next    = off_reg;
        cur_next    = cur_reg;
        lvl_next    = lvl_reg;
        paddr_next  = paddr_reg;
        status_next = status_reg;
        page_sel    = mem_rdata[DATA_W-1:1];
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = {cur_reg, idx_cur};
        mem_wdata   = '0;
        mem_raddr   = {cur_reg, idx_cur};

        case (state_reg)
            mlptw_pkg::WS_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = mlptw_pkg::WS_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end

            mlptw_pkg::WS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next   = in_mode;
                    walk_next   = vext[PAGE_OFFSET_BITS +: WALK_W];
                    off_next    = in_vaddr[PAGE_OFFSET_BITS-1:0];
                    lvl_next    = '0;
                    paddr_next  = mlptw_pkg::PADDR_FAULT;
                    if (root_reg != '0)
                    begin
                        cur_next   = root_reg;
                        state_next = mlptw_pkg::WS_ISSUE;
                    end
                    else if (in_mode == mlptw_pkg::MODE_XLATE)
                    begin
                        status_next = mlptw_pkg::ST_UNMAPPED;
                        state_next  = mlptw_pkg::WS_RESULT;
                    end
                    else if (!pages_left)
                    begin
                        status_next = mlptw_pkg::ST_NO_PAGES;
                        state_next  = mlptw_pkg::WS_RESULT;
                    end
                    else
                    begin
                        root_next  = free_reg[PAGE_W-1:0];
                        cur_next   = free_reg[PAGE_W-1:0];
                        free_next  = free_reg + CNT_W'(1);
                        state_next = mlptw_pkg::WS_ISSUE;
                    end
                end
            end

            mlptw_pkg::WS_ISSUE:
            begin
                mem_raddr  = {cur_reg, idx_cur};
                state_next = mlptw_pkg::WS_WALK;
            end

            mlptw_pkg::WS_WALK:
            begin
                if (!mem_rdata[0])
                begin
                    if (mode_reg == mlptw_pkg::MODE_XLATE)
                    begin
                        status_next = mlptw_pkg::ST_UNMAPPED;
                        state_next  = mlptw_pkg::WS_RESULT;
                    end
                    else if (!pages_left)
                    begin
                        status_next = mlptw_pkg::ST_NO_PAGES;
                        state_next  = mlptw_pkg::WS_RESULT;
                    end
                    else
                    begin
                        page_sel  = free_reg[PAGE_W-1:0];
                        free_next = free_reg + CNT_W'(1);
                        mem_we    = 1'b1;
                        mem_wdata = {free_reg[PAGE_W-1:0], 1'b1};
                    end
                end
                if (mem_rdata[0] || (mode_reg == mlptw_pkg::MODE_ALLOC && pages_left))
                begin
                    if (lvl_reg == LVL_W'(LEVELS - 1))
                    begin
                        paddr_next  = mlptw_pkg::PADDR_W'({page_sel, off_reg});
                        status_next = mlptw_pkg::ST_OK;
                        state_next  = mlptw_pkg::WS_RESULT;
                    end
                    else
                    begin
                        // next table is always a younger page, never the one written now
                        mem_raddr = {page_sel, walk_shift[WALK_W-1 -: IDX_W]};
                        walk_next = walk_shift;
                        cur_next  = page_sel;
                        lvl_next  = lvl_reg + LVL_W'(1);
                    end
                end
            end

            mlptw_pkg::WS_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = mlptw_pkg::WS_IDLE;
                end
            end

            default:
            begin
                state_next = mlptw_pkg::WS_IDLE;
            end
        endcase
    end

    assign res_paddr  = paddr_reg;
    assign res_status = status_reg;

endmodule

@@ hdl/multilevel_page_table_walker.sv @@
// Page table walker with a bump page allocator. tuser bit 0 selects allocate (0) or
// translate (1); tdata carries the 64-bit virtual address. Each item yields one result:
// tdata is the physical address, tuser the status (0 ok, 1 not mapped, 2 out of pages),
// and the address is all ones whenever status is not ok. After reset the table memory
// is swept clear, one entry per cycle, over all PHYS_PAGES * 2^(PAGE_OFFSET_BITS-3)
// entries (32768 at the defaults) with s_axis_tready low. Walks do not overlap: an
// item is taken only between walks, which make one table read per level through the
// single registered-read table memory; faults end the walk early. The next item is taken
// while a finished result waits on m_axis_tready.
module multilevel_page_table_walker #(
    parameter int PAGE_OFFSET_BITS = mlptw_pkg::PAGE_OFFSET_BITS_DEF,
    parameter int LEVELS           = mlptw_pkg::LEVELS_DEF,
    parameter int PHYS_PAGES       = mlptw_pkg::PHYS_PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // vaddr
    input  logic [0:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // paddr
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int IDX_W  = PAGE_OFFSET_BITS - mlptw_pkg::PTE_MARK_BITS;
    localparam int PAGE_W = $clog2(PHYS_PAGES);
    localparam int ADDR_W = PAGE_W + IDX_W;
    localparam int DATA_W = PAGE_W + 1;
    localparam int DEPTH  = PHYS_PAGES * (1 << IDX_W);

    logic                          res_valid;
    logic                          res_ready;
    logic [mlptw_pkg::PADDR_W-1:0] res_paddr;
    mlptw_pkg::status_t            res_status;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [DATA_W-1:0]             mem_wdata;
    logic [ADDR_W-1:0]             mem_raddr;
    logic [DATA_W-1:0]             mem_rdata;

    logic                          out_valid_reg, out_valid_next;
    logic [mlptw_pkg::PADDR_W-1:0] out_paddr_reg, out_paddr_next;
    logic [1:0]                    out_status_reg, out_status_next;

    mlptw_walker #(
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
        .LEVELS           (LEVELS),
        .PHYS_PAGES       (PHYS_PAGES)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_mode    (s_axis_tuser[0]),
        .in_vaddr   (s_axis_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_paddr  (res_paddr),
        .res_status (res_status),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    mlptw_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_paddr_next  = out_paddr_reg;
        out_status_next = out_status_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next  = 1'b1;
            out_paddr_next  = res_paddr;
            out_status_next = res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_paddr_reg  <= out_paddr_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_paddr_reg;
    assign m_axis_tuser  = out_status_reg;

    a_one_walk_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while a walk was in progress");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_paddr) && $stable(res_status))
        else $error("walker dropped or changed a pending result");

    a_fault_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != mlptw_pkg::ST_OK |->
            m_axis_tdata == mlptw_pkg::PADDR_FAULT)
        else $error("faulting result without all-ones address");

endmodule

@@ tb/tb_multilevel_page_table_walker.sv @@
module tb_multilevel_page_table_walker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PGO      = mlptw_pkg::PAGE_OFFSET_BITS_DEF;
    localparam int NLEVELS  = mlptw_pkg::LEVELS_DEF;
    localparam int NPAGES   = mlptw_pkg::PHYS_PAGES_DEF;
    localparam int IDX_W    = PGO - mlptw_pkg::PTE_MARK_BITS;
    localparam int ENTRIES  = 1 << IDX_W;
    localparam int DEPTH    = NPAGES * ENTRIES;
    localparam int WALK_TOP = PGO + NLEVELS * IDX_W;
    localparam logic [63:0] OFF_MASK  = (64'd1 << PGO) - 64'd1;
    localparam logic [63:0] WALK_MASK = ((WALK_TOP >= 64) ? {64{1'b1}}
                                        : ((64'd1 << WALK_TOP) - 64'd1)) & ~OFF_MASK;
    localparam int WATCHDOG = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int DIR_ROWS = 19;
    localparam int RAND_PER_PHASE = 270;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // vaddr
    logic [0:0]  s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // paddr
    logic [1:0]  m_axis_tuser;   // status

    multilevel_page_table_walker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    typedef struct packed {
        logic [63:0]        paddr;
        mlptw_pkg::status_t status;
    } xlate_t;

    typedef struct packed {
        logic               mode;
        logic [63:0]        vaddr;
        logic [63:0]        stride;
        logic [7:0]         count;
        logic               typed;
        logic [63:0]        paddr;
        mlptw_pkg::status_t status;
    } dir_row_t;

    // shadow page tables
    bit          pt_valid [DEPTH];
    int unsigned pt_page  [DEPTH];
    int unsigned root_pg;
    int unsigned next_pg;

    xlate_t      pending_xlate [$];
    logic [63:0] mapped_va [$];
    dir_row_t    dir_tbl [DIR_ROWS];

    int errors;
    int results_seen;
    int idle_cycles;
    int src_idle_pct;
    int snk_idle_pct;
    bit hold_go;
    bit hold_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void walk_tables(input logic mode, input logic [63:0] va,
                                        output logic [63:0] pa,
                                        output mlptw_pkg::status_t st);
        logic [63:0] vpn;
        int unsigned cur;
        int unsigned slot;
        int unsigned sh;
        bit          alloc;
        pa = mlptw_pkg::PADDR_FAULT;
        st = mlptw_pkg::ST_UNMAPPED;
        alloc = (mode == mlptw_pkg::MODE_ALLOC);
        vpn = va >> PGO;
        if (root_pg == 0)
        begin
            if (!alloc)
                return;
            if (next_pg >= NPAGES)
            begin
                st = mlptw_pkg::ST_NO_PAGES;
                return;
            end
            root_pg = next_pg;
            next_pg++;
        end
        cur = root_pg;
        for (int lvl = 0; lvl < NLEVELS; lvl++)
        begin
            // fields above bit 63 shift out to 0
            sh = (NLEVELS - 1 - lvl) * IDX_W;
            slot = cur * ENTRIES + int'((vpn >> sh) & 64'(ENTRIES - 1));
            if (slot >= DEPTH)
                return;
            if (!pt_valid[slot])
            begin
                if (!alloc)
                    return;
                if (next_pg >= NPAGES)
                begin
                    st = mlptw_pkg::ST_NO_PAGES;
                    return;
                end
                pt_valid[slot] = 1'b1;
                pt_page[slot] = next_pg;
                next_pg++;
            end
            cur = pt_page[slot];
        end
        pa = (64'(cur) << PGO) | (va & OFF_MASK);
        st = mlptw_pkg::ST_OK;
    endfunction

    // mostly mapped addresses with random offset and upper bits, some near misses, some noise
    function automatic logic [63:0] pick_vaddr();
        logic [63:0] va;
        logic [63:0] base;
        logic [63:0] field;
        int          kind;
        int          lvl;
        va = {$urandom, $urandom};
        kind = $urandom_range(99);
        if (mapped_va.size() != 0 && kind < 85)
        begin
            base = mapped_va[$urandom_range(mapped_va.size() - 1)];
            if (kind < 60)
                va = (base & WALK_MASK) | (va & ~WALK_MASK);
            else
            begin
                lvl = $urandom_range(NLEVELS - 1);
                field = 64'(ENTRIES - 1) << (PGO + (NLEVELS - 1 - lvl) * IDX_W);
                va = (base & WALK_MASK & ~field) | (va & (~WALK_MASK | field));
            end
        end
        return va;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        errors++;
    endtask

    task automatic send_item(input logic mode, input logic [63:0] va, input logic typed,
                             input logic [63:0] t_pa, input mlptw_pkg::status_t t_st);
        logic [63:0]        pa;
        mlptw_pkg::status_t st;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = va;
        s_axis_tuser = mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        walk_tables(mode, va, pa, st);
        if (mode == mlptw_pkg::MODE_ALLOC && st == mlptw_pkg::ST_OK)
            mapped_va.push_back(va);
        if (typed)
            pending_xlate.push_back('{paddr: t_pa, status: t_st});
        else
            pending_xlate.push_back('{paddr: pa, status: st});
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        xlate_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_xlate.size() == 0)
                report_mismatch("result with nothing pending", m_axis_tdata, '0);
            else
            begin
                e = pending_xlate.pop_front();
                if (m_axis_tdata !== e.paddr)
                    report_mismatch("paddr", m_axis_tdata, e.paddr);
                if (m_axis_tuser !== e.status)
                    report_mismatch("status", 64'(m_axis_tuser), 64'(e.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG)
        begin
            $display("tb_multilevel_page_table_walker NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver side
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            m_axis_tready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        logic [63:0] va;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        errors = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_go = 1'b0;
        hold_done = 1'b0;
        root_pg = 0;
        next_pg = 1;
        src_idle_pct = 26;
        snk_idle_pct = 77;

        dir_tbl = '{
            // no root yet
            '{mlptw_pkg::MODE_XLATE, 64'h0000_0000_0000_0000, 64'h0, 8'd1, 1'b1,
              mlptw_pkg::PADDR_FAULT, mlptw_pkg::ST_UNMAPPED},
            '{mlptw_pkg::MODE_XLATE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'd1, 1'b1,
              mlptw_pkg::PADDR_FAULT, mlptw_pkg::ST_UNMAPPED},
            // root 1, tables 2..4, data page 5
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0000_0000_0000, 64'h0, 8'd1, 1'b1,
              64'h5000, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0000_0000_0FFF, 64'h0, 8'd1, 1'b1,
              64'h5FFF, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_XLATE, 64'h0000_0000_0000_1000, 64'h0, 8'd1, 1'b1,
              mlptw_pkg::PADDR_FAULT, mlptw_pkg::ST_UNMAPPED},
            '{mlptw_pkg::MODE_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            // upper bits ignored
            '{mlptw_pkg::MODE_XLATE, 64'h0000_FFFF_FFFF_F000, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_XLATE, 64'hFFFF_0000_0000_0123, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            // new entry at each level
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0080_0000_0000, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0000_4000_0000, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0000_0020_0000, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0000_0000_1000, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_XLATE, 64'h0000_0100_0000_0000, 64'h0, 8'd1, 1'b1,
              mlptw_pkg::PADDR_FAULT, mlptw_pkg::ST_UNMAPPED},
            '{mlptw_pkg::MODE_XLATE, 64'h0000_0000_8000_0000, 64'h0, 8'd1, 1'b1,
              mlptw_pkg::PADDR_FAULT, mlptw_pkg::ST_UNMAPPED},
            // use up the pages
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0100_0000_0000, 64'h0000_0080_0000_0000,
              8'd10, 1'b0, '0, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0000_C000_0000, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            // runs out mid walk, partial tables stay
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0600_0000_0000, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_XLATE, 64'h0000_0600_0000_0000, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK},
            '{mlptw_pkg::MODE_ALLOC, 64'h0000_0000_0000_0ABC, 64'h0, 8'd1, 1'b0,
              '0, mlptw_pkg::ST_OK}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            va = dir_tbl[r].vaddr;
            for (int k = 0; k < int'(dir_tbl[r].count); k++)
            begin
                send_item(dir_tbl[r].mode, va, dir_tbl[r].typed, dir_tbl[r].paddr,
                          dir_tbl[r].status);
                va = va + dir_tbl[r].stride;
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 26;
                    snk_idle_pct = 77;
                end
                1:
                begin
                    src_idle_pct = 77;
                    snk_idle_pct = 26;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    hold_go = 1'b1;
                end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++)
                send_item(logic'($urandom_range(1)), pick_vaddr(), 1'b0, '0,
                          mlptw_pkg::ST_OK);
        end
        s_axis_tvalid = 1'b0;

        while (pending_xlate.size() != 0)
            @(posedge clk);
        repeat (4 * (NLEVELS + 3)) @(posedge clk);

        if (errors == 0)
            $display("tb_multilevel_page_table_walker OK");
        else
            $display("tb_multilevel_page_table_walker NOT OK");
        $finish;
    end

endmodule
